FILE: rtl/core/nms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nms_pkg
// Shared types, codes and default sizes for the normalized MLP scorer.
// ----------------------------------------------------------------------------
package nms_pkg;

    // Default sizes handed to the top level parameters
    localparam int MAX_INPUTS_DEF = 2048;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_LAYERS_DEF = 4;
    localparam int FRAC_BITS_DEF  = 16;

    // Entries in the job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Configuration port
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LAYER0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LAYER1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LAYER2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LAYER3 = 3'd6;

    // Configuration reset values
    localparam logic [11:0] RST_INPUT_COUNT = 12'd172;
    localparam logic [2:0]  RST_LAYER_COUNT = 3'd2;
    localparam logic [3:0]  RST_RELU_MASK   = 4'd1;
    localparam logic [8:0]  RST_WIDTH0      = 9'd64;
    localparam logic [8:0]  RST_WIDTH_REST  = 9'd1;

    // Item operations
    typedef enum logic [1:0] {
        OP_NORM    = 2'd0,
        OP_WEIGHT  = 2'd1,
        OP_BIAS    = 2'd2,
        OP_FEATURE = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_COUNT = 2'd1,
        ST_ZERO  = 2'd2,
        ST_SAT   = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         layer_sel;
        logic [7:0]         neuron;
        logic [10:0]        position;
        logic signed [31:0] value;
        logic signed [31:0] spread;
        logic               last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] score;
        logic [1:0]         status;
    } out_t;

    typedef struct packed {
        logic [11:0]     input_count;
        logic [2:0]      layer_count;
        logic [3:0]      relu_mask;
        logic [3:0][8:0] width_layer;
    } cfg_t;

    // One scoring job handed from front to back
    typedef struct packed {
        logic mismatch;
    } job_t;

endpackage

FILE: rtl/core/normalized_mlp_scorer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// normalized_mlp_scorer
// Scores one feature vector with a small dense network in Q16.16.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+---------------------------
//  in      | input     | in_valid / in_ready   | in_data  (nms_pkg::in_t)
//  out     | output    | out_valid / out_ready | out_data (nms_pkg::out_t)
//  cfg     | input     | cfg_write             | cfg_index, cfg_data
//
//  Loads and features other than the last are accepted whenever the input is open.
//  A last feature starts a job: a std check, normalization of each feature
//  (one quotient bit per cycle in the divider), then per neuron a pass over
//  its fan_in on the single weight read port and MAC.
//  The input holds off while a job is queued or running; a finished result
//  waits in the output register without blocking the next vector's loads.
//  Reset is asynchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module normalized_mlp_scorer #(
    parameter int MAX_INPUTS = nms_pkg::MAX_INPUTS_DEF,
    parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_LAYERS = nms_pkg::MAX_LAYERS_DEF,
    parameter int FRAC_BITS  = nms_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nms_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire nms_pkg::in_t                   in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output nms_pkg::out_t                       out_data
);

    localparam int FAW     = $clog2(MAX_INPUTS);
    localparam int L0_SIZE = MAX_INPUTS * MAX_WIDTH;
    localparam int LK_SIZE = MAX_WIDTH * MAX_WIDTH;
    localparam int WDEPTH  = L0_SIZE + (MAX_LAYERS - 1) * LK_SIZE;
    localparam int WAW     = $clog2(WDEPTH);
    localparam int BDEPTH  = MAX_LAYERS * MAX_WIDTH;
    localparam int BAW     = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
    localparam int AAW     = $clog2(2 * MAX_WIDTH);

    nms_pkg::cfg_t  cfg;
    nms_pkg::job_t  push_job, pop_job;
    logic           job_push, job_pop, q_empty, q_full, back_idle, open;

    logic           norm_we;
    logic [FAW-1:0] norm_waddr, norm_raddr;
    logic [63:0]    norm_wdata, norm_rdata;
    logic           weight_we;
    logic [WAW-1:0] weight_waddr, weight_raddr;
    logic [31:0]    weight_wdata, weight_rdata;
    logic           bias_we;
    logic [BAW-1:0] bias_waddr, bias_raddr;
    logic [31:0]    bias_wdata, bias_rdata;
    logic           front_feat_we, back_feat_we, feat_we;
    logic [FAW-1:0] front_feat_waddr, back_feat_waddr, feat_waddr, feat_raddr;
    logic [31:0]    front_feat_wdata, back_feat_wdata, feat_wdata, feat_rdata;
    logic           act_we;
    logic [AAW-1:0] act_waddr, act_raddr;
    logic [31:0]    act_wdata, act_rdata;

    // Hold items off while a job is queued or the back is busy, so the
    // stores stay stable under the running job.
    assign open = back_idle && q_empty && !q_full;

    // Feature buffer: the front fills it, the back rewrites it normalized.
    // The two never write in the same cycle.
    assign feat_we    = front_feat_we || back_feat_we;
    assign feat_waddr = back_feat_we ? back_feat_waddr : front_feat_waddr;
    assign feat_wdata = back_feat_we ? back_feat_wdata : front_feat_wdata;

    nms_front #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LAYERS (MAX_LAYERS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .open         (open),
        .job_push     (job_push),
        .job          (push_job),
        .norm_we      (norm_we),
        .norm_waddr   (norm_waddr),
        .norm_wdata   (norm_wdata),
        .weight_we    (weight_we),
        .weight_waddr (weight_waddr),
        .weight_wdata (weight_wdata),
        .bias_we      (bias_we),
        .bias_waddr   (bias_waddr),
        .bias_wdata   (bias_wdata),
        .feat_we      (front_feat_we),
        .feat_waddr   (front_feat_waddr),
        .feat_wdata   (front_feat_wdata)
    );

    nms_queue #(
        .DEPTH (nms_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_push),
        .push_data (push_job),
        .pop       (job_pop),
        .pop_data  (pop_job),
        .empty     (q_empty),
        .full      (q_full)
    );

    nms_back #(
        .MAX_INPUTS (MAX_INPUTS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_LAYERS (MAX_LAYERS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (pop_job),
        .q_pop        (job_pop),
        .idle         (back_idle),
        .norm_raddr   (norm_raddr),
        .norm_rdata   (norm_rdata),
        .feat_raddr   (feat_raddr),
        .feat_rdata   (feat_rdata),
        .feat_we      (back_feat_we),
        .feat_waddr   (back_feat_waddr),
        .feat_wdata   (back_feat_wdata),
        .weight_raddr (weight_raddr),
        .weight_rdata (weight_rdata),
        .bias_raddr   (bias_raddr),
        .bias_rdata   (bias_rdata),
        .act_we       (act_we),
        .act_waddr    (act_waddr),
        .act_wdata    (act_wdata),
        .act_raddr    (act_raddr),
        .act_rdata    (act_rdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    // Mean in the upper half, std in the lower half
    nms_ram #(
        .WIDTH (64),
        .DEPTH (MAX_INPUTS)
    ) u_norm_ram (
        .clk   (clk),
        .we    (norm_we),
        .waddr (norm_waddr),
        .wdata (norm_wdata),
        .raddr (norm_raddr),
        .rdata (norm_rdata)
    );

    nms_ram #(
        .WIDTH (32),
        .DEPTH (WDEPTH)
    ) u_weight_ram (
        .clk   (clk),
        .we    (weight_we),
        .waddr (weight_waddr),
        .wdata (weight_wdata),
        .raddr (weight_raddr),
        .rdata (weight_rdata)
    );

    nms_ram #(
        .WIDTH (32),
        .DEPTH (BDEPTH)
    ) u_bias_ram (
        .clk   (clk),
        .we    (bias_we),
        .waddr (bias_waddr),
        .wdata (bias_wdata),
        .raddr (bias_raddr),
        .rdata (bias_rdata)
    );

    nms_ram #(
        .WIDTH (32),
        .DEPTH (MAX_INPUTS)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (feat_wdata),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    // Two banks of activations, alternating by layer
    nms_ram #(
        .WIDTH (32),
        .DEPTH (2 * MAX_WIDTH)
    ) u_act_ram (
        .clk   (clk),
        .we    (act_we),
        .waddr (act_waddr),
        .wdata (act_wdata),
        .raddr (act_raddr),
        .rdata (act_rdata)
    );

endmodule
`default_nettype wire

FILE: rtl/core/nms_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nms_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module nms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/nms_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nms_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module nms_queue #(
    parameter int DEPTH = nms_pkg::QUEUE_DEPTH
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire nms_pkg::job_t push_data,
    input  wire logic          pop,
    output nms_pkg::job_t      pop_data,
    output logic               empty,
    output logic               full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    nms_pkg::job_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == NW'(DEPTH));
    assign pop_data = entry_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/nms_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nms_div
// Radix-2 restoring divider for feature normalization: (diff << F) / std,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module nms_div #(
    parameter int FRAC_BITS = nms_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [32:0] diff,
    input  wire logic signed [31:0] den,
    output logic                    done,
    output logic signed [31:0]      quot,
    output logic                    sat
);

    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] q_reg, q_next;
    logic [31:0]   rem_reg, rem_next;
    logic [31:0]   den_reg, den_next;
    logic          neg_reg, neg_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [32:0]   trial;
    logic [32:0]   diff_mag;
    logic          fits;

    always_comb
    begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        diff_mag  = diff[32] ? 33'(-diff) : 33'(diff);
        trial     = {rem_reg, num_reg[NW-1]};
        if (start)
        begin
            num_next = {diff_mag[31:0], {FRAC_BITS{1'b0}}};
            den_next = den[31] ? 32'(-den) : 32'(den);
            neg_next = diff[32] ^ den[31];
            rem_next = '0;
            q_next   = '0;
            cnt_next = CW'(NW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            // shift in one dividend bit, subtract when it fits
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = 32'(trial - {1'b0, den_reg});
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[31:0];
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            num_next = {num_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // Saturate the signed quotient
    always_comb
    begin
        if (neg_reg)
        begin
            fits = (q_reg[NW-1:32] == '0) && !(q_reg[31] && (q_reg[30:0] != '0));
            quot = fits ? 32'(-q_reg[31:0]) : 32'sh8000_0000;
        end
        else
        begin
            fits = (q_reg[NW-1:31] == '0);
            quot = fits ? 32'(q_reg[31:0]) : 32'sh7FFF_FFFF;
        end
        sat = !fits;
    end

    assign done = done_reg;

endmodule
`default_nettype wire

FILE: rtl/core/nms_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nms_front
// Accepts items and configuration, writes loads into the stores, counts
// features and queues a scoring job on the last feature of a vector.
// ----------------------------------------------------------------------------
module nms_front #(
    parameter int MAX_INPUTS = nms_pkg::MAX_INPUTS_DEF,
    parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_LAYERS = nms_pkg::MAX_LAYERS_DEF,
    localparam int FAW = $clog2(MAX_INPUTS),
    localparam int L0_SIZE = MAX_INPUTS * MAX_WIDTH,
    localparam int LK_SIZE = MAX_WIDTH * MAX_WIDTH,
    localparam int WDEPTH = L0_SIZE + (MAX_LAYERS - 1) * LK_SIZE,
    localparam int WAW = $clog2(WDEPTH),
    localparam int BDEPTH = MAX_LAYERS * MAX_WIDTH,
    localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [nms_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [nms_pkg::CFG_DATA_W-1:0]    cfg_data,
    output nms_pkg::cfg_t                          cfg,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire nms_pkg::in_t                      in_data,
    input  wire logic                              open,
    output logic                                   job_push,
    output nms_pkg::job_t                          job,
    output logic                                   norm_we,
    output logic [FAW-1:0]                         norm_waddr,
    output logic [63:0]                            norm_wdata,
    output logic                                   weight_we,
    output logic [WAW-1:0]                         weight_waddr,
    output logic [31:0]                            weight_wdata,
    output logic                                   bias_we,
    output logic [BAW-1:0]                         bias_waddr,
    output logic [31:0]                            bias_wdata,
    output logic                                   feat_we,
    output logic [FAW-1:0]                         feat_waddr,
    output logic [31:0]                            feat_wdata
);

    nms_pkg::cfg_t cfg_reg, cfg_next;
    logic [11:0]   count_reg, count_next;
    logic [11:0]   count_inc;
    logic          accept;
    logic          pos_ok, layer_ok, neuron_ok, col_ok;
    nms_pkg::op_t  op;

    assign cfg      = cfg_reg;
    assign in_ready = open;
    assign accept   = in_valid && open;
    assign op       = nms_pkg::op_t'(in_data.operation);

    // Configuration writes; unknown indexes drop
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                nms_pkg::CFG_INPUT_COUNT:  cfg_next.input_count    = cfg_data;
                nms_pkg::CFG_LAYER_COUNT:  cfg_next.layer_count    = cfg_data[2:0];
                nms_pkg::CFG_RELU_MASK:    cfg_next.relu_mask      = cfg_data[3:0];
                nms_pkg::CFG_WIDTH_LAYER0: cfg_next.width_layer[0] = cfg_data[8:0];
                nms_pkg::CFG_WIDTH_LAYER1: cfg_next.width_layer[1] = cfg_data[8:0];
                nms_pkg::CFG_WIDTH_LAYER2: cfg_next.width_layer[2] = cfg_data[8:0];
                nms_pkg::CFG_WIDTH_LAYER3: cfg_next.width_layer[3] = cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // Classify and route the item
    always_comb
    begin
        pos_ok    = 32'(in_data.position) < MAX_INPUTS;
        layer_ok  = 32'(in_data.layer_sel) < MAX_LAYERS;
        neuron_ok = 32'(in_data.neuron) < MAX_WIDTH;
        col_ok    = (in_data.layer_sel == 2'd0) ? pos_ok
                                                : (32'(in_data.position) < MAX_WIDTH);
        count_inc = (count_reg == 12'hFFF) ? count_reg : count_reg + 12'd1;

        norm_we      = 1'b0;
        weight_we    = 1'b0;
        bias_we      = 1'b0;
        feat_we      = 1'b0;
        job_push     = 1'b0;
        job.mismatch = 1'b0;
        count_next   = count_reg;

        norm_waddr   = FAW'(in_data.position);
        norm_wdata   = {in_data.value, in_data.spread};
        feat_waddr   = FAW'(in_data.position);
        feat_wdata   = in_data.value;
        bias_waddr   = BAW'(32'(in_data.layer_sel) * MAX_WIDTH + 32'(in_data.neuron));
        bias_wdata   = in_data.value;
        weight_wdata = in_data.value;
        if (in_data.layer_sel == 2'd0)
        begin
            weight_waddr = WAW'(32'(in_data.neuron) * MAX_INPUTS + 32'(in_data.position));
        end
        else
        begin
            weight_waddr = WAW'(L0_SIZE + (32'(in_data.layer_sel) - 1) * LK_SIZE
                                + 32'(in_data.neuron) * MAX_WIDTH + 32'(in_data.position));
        end

        if (accept)
        begin
            case (op)
                nms_pkg::OP_NORM:
                begin
                    norm_we = pos_ok;
                end
                nms_pkg::OP_WEIGHT:
                begin
                    weight_we = layer_ok && neuron_ok && col_ok;
                end
                nms_pkg::OP_BIAS:
                begin
                    bias_we = layer_ok && neuron_ok;
                end
                nms_pkg::OP_FEATURE:
                begin
                    feat_we = pos_ok;
                    if (in_data.last)
                    begin
                        job_push     = 1'b1;
                        job.mismatch = (cfg_reg.input_count == 12'd0)
                                    || (32'(cfg_reg.input_count) > MAX_INPUTS)
                                    || (count_inc != cfg_reg.input_count);
                        count_next   = '0;
                    end
                    else
                    begin
                        count_next = count_inc;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.input_count    <= nms_pkg::RST_INPUT_COUNT;
            cfg_reg.layer_count    <= nms_pkg::RST_LAYER_COUNT;
            cfg_reg.relu_mask      <= nms_pkg::RST_RELU_MASK;
            cfg_reg.width_layer[0] <= nms_pkg::RST_WIDTH0;
            cfg_reg.width_layer[1] <= nms_pkg::RST_WIDTH_REST;
            cfg_reg.width_layer[2] <= nms_pkg::RST_WIDTH_REST;
            cfg_reg.width_layer[3] <= nms_pkg::RST_WIDTH_REST;
            count_reg              <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/nms_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nms_back
// Runs one scoring job: zero-std check, normalization through the divider,
// dense layers on one shared multiply-accumulate path, then the result.
// ----------------------------------------------------------------------------
module nms_back #(
    parameter int MAX_INPUTS = nms_pkg::MAX_INPUTS_DEF,
    parameter int MAX_WIDTH  = nms_pkg::MAX_WIDTH_DEF,
    parameter int MAX_LAYERS = nms_pkg::MAX_LAYERS_DEF,
    parameter int FRAC_BITS  = nms_pkg::FRAC_BITS_DEF,
    localparam int FAW = $clog2(MAX_INPUTS),
    localparam int L0_SIZE = MAX_INPUTS * MAX_WIDTH,
    localparam int LK_SIZE = MAX_WIDTH * MAX_WIDTH,
    localparam int WDEPTH = L0_SIZE + (MAX_LAYERS - 1) * LK_SIZE,
    localparam int WAW = $clog2(WDEPTH),
    localparam int BDEPTH = MAX_LAYERS * MAX_WIDTH,
    localparam int BAW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1,
    localparam int AAW = $clog2(2 * MAX_WIDTH)
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire nms_pkg::cfg_t   cfg,
    input  wire logic            q_empty,
    input  wire nms_pkg::job_t   q_data,
    output logic                 q_pop,
    output logic                 idle,
    output logic [FAW-1:0]       norm_raddr,
    input  wire logic [63:0]     norm_rdata,
    output logic [FAW-1:0]       feat_raddr,
    input  wire logic [31:0]     feat_rdata,
    output logic                 feat_we,
    output logic [FAW-1:0]       feat_waddr,
    output logic [31:0]          feat_wdata,
    output logic [WAW-1:0]       weight_raddr,
    input  wire logic [31:0]     weight_rdata,
    output logic [BAW-1:0]       bias_raddr,
    input  wire logic [31:0]     bias_rdata,
    output logic                 act_we,
    output logic [AAW-1:0]       act_waddr,
    output logic [31:0]          act_wdata,
    output logic [AAW-1:0]       act_raddr,
    input  wire logic [31:0]     act_rdata,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output nms_pkg::out_t        out_data
);

    localparam int MAXC = (MAX_INPUTS > MAX_WIDTH) ? MAX_INPUTS : MAX_WIDTH;
    localparam int CW   = $clog2(MAXC + 1);
    localparam int WCW  = $clog2(MAX_WIDTH + 1);
    localparam int LIM  = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_ZCHK  = 11'b000_0000_0010,
        S_ZFIN  = 11'b000_0000_0100,
        S_NRD   = 11'b000_0000_1000,
        S_NDIV  = 11'b000_0001_0000,
        S_NWAIT = 11'b000_0010_0000,
        S_LBIAS = 11'b000_0100_0000,
        S_LACC  = 11'b000_1000_0000,
        S_LMAC  = 11'b001_0000_0000,
        S_LEND  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      j_reg, j_next;
    logic [1:0]         k_reg, k_next;
    logic [WAW-1:0]     base_reg, base_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [63:0] prod_reg;
    logic               p1_reg, p1_next;
    logic               p2_reg;
    logic               zv_reg, zv_next;
    logic               zero_reg, zero_next;
    logic               sat_reg, sat_next;
    logic [31:0]        score_reg, score_next;
    logic [1:0]         status_reg, status_next;
    logic               out_valid_reg, out_valid_next;
    nms_pkg::out_t      out_data_reg, out_data_next;

    logic [CW-1:0]      n_c;
    logic [2:0]         layers;
    logic [WCW-1:0]     width_k;
    logic [CW-1:0]      fan_in;
    logic [31:0]        src_data;
    logic               div_start;
    logic signed [32:0] div_diff;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic               div_sat;
    logic               acc_sat;
    logic [31:0]        neuron_val;

    function automatic logic [WCW-1:0] eff_width(input logic [8:0] w);
        if (w == 9'd0)
        begin
            return WCW'(1);
        end
        if (32'(w) > MAX_WIDTH)
        begin
            return WCW'(MAX_WIDTH);
        end
        return WCW'(w);
    endfunction

    function automatic logic [WAW-1:0] layer_base(input logic [1:0] k);
        if (k == 2'd0)
        begin
            return '0;
        end
        return WAW'(L0_SIZE + (32'(k) - 1) * LK_SIZE);
    endfunction

    nms_div #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .diff  (div_diff),
        .den   (norm_rdata[31:0]),
        .done  (div_done),
        .quot  (div_quot),
        .sat   (div_sat)
    );

    // Layer geometry from configuration
    always_comb
    begin
        n_c = CW'(cfg.input_count);
        if (cfg.layer_count == 3'd0)
        begin
            layers = 3'd1;
        end
        else if (32'(cfg.layer_count) > LIM)
        begin
            layers = 3'(LIM);
        end
        else
        begin
            layers = cfg.layer_count;
        end
        width_k = eff_width(cfg.width_layer[k_reg]);
        fan_in  = (k_reg == 2'd0) ? n_c : CW'(eff_width(cfg.width_layer[k_reg - 2'd1]));
    end

    // Store addresses
    always_comb
    begin
        norm_raddr   = FAW'(i_reg);
        feat_raddr   = (state_reg == S_LMAC) ? FAW'(j_reg) : FAW'(i_reg);
        feat_we      = (state_reg == S_NWAIT) && div_done;
        feat_waddr   = FAW'(i_reg);
        feat_wdata   = div_quot;
        weight_raddr = base_reg + WAW'(j_reg);
        bias_raddr   = BAW'(32'(k_reg) * MAX_WIDTH + 32'(i_reg));
        act_raddr    = AAW'((k_reg[0] ? 0 : MAX_WIDTH) + 32'(j_reg));
        act_waddr    = AAW'((k_reg[0] ? MAX_WIDTH : 0) + 32'(i_reg));
        src_data     = (k_reg == 2'd0) ? feat_rdata : act_rdata;
        div_diff     = 33'(signed'(feat_rdata)) - 33'(signed'(norm_rdata[63:32]));
        div_start    = (state_reg == S_NDIV);
    end

    // Saturate and rectify the neuron total
    always_comb
    begin
        acc_sat = !((acc_reg[63:31] == '0) || (acc_reg[63:31] == '1));
        if (acc_sat)
        begin
            neuron_val = acc_reg[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            neuron_val = acc_reg[31:0];
        end
        if (cfg.relu_mask[k_reg] && neuron_val[31])
        begin
            neuron_val = '0;
        end
        act_we    = (state_reg == S_LEND);
        act_wdata = neuron_val;
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        p1_next        = 1'b0;
        zv_next        = 1'b0;
        zero_next      = zero_reg || (zv_reg && (norm_rdata[31:0] == '0));
        sat_next       = sat_reg;
        score_next     = score_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;

        // accumulate one registered product per cycle
        if (p2_reg)
        begin
            acc_next = acc_reg + (prod_reg >>> FRAC_BITS);
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    i_next     = '0;
                    zero_next  = 1'b0;
                    sat_next   = 1'b0;
                    score_next = '0;
                    if (q_data.mismatch)
                    begin
                        status_next = nms_pkg::ST_COUNT;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        status_next = nms_pkg::ST_OK;
                        state_next  = S_ZCHK;
                    end
                end
            end
            S_ZCHK:
            begin
                if (i_reg < n_c)
                begin
                    zv_next = 1'b1;
                    i_next  = i_reg + CW'(1);
                end
                else
                begin
                    state_next = S_ZFIN;
                end
            end
            S_ZFIN:
            begin
                i_next = '0;
                if (zero_reg)
                begin
                    status_next = nms_pkg::ST_ZERO;
                    state_next  = S_OUT;
                end
                else
                begin
                    state_next = S_NRD;
                end
            end
            S_NRD:
            begin
                state_next = S_NDIV;
            end
            S_NDIV:
            begin
                state_next = S_NWAIT;
            end
            S_NWAIT:
            begin
                if (div_done)
                begin
                    sat_next = sat_reg || div_sat;
                    i_next   = i_reg + CW'(1);
                    if (i_reg + CW'(1) == n_c)
                    begin
                        i_next     = '0;
                        k_next     = '0;
                        base_next  = layer_base(2'd0);
                        state_next = S_LBIAS;
                    end
                    else
                    begin
                        state_next = S_NRD;
                    end
                end
            end
            S_LBIAS:
            begin
                state_next = S_LACC;
            end
            S_LACC:
            begin
                acc_next   = 64'(signed'(bias_rdata));
                j_next     = '0;
                state_next = S_LMAC;
            end
            S_LMAC:
            begin
                if (j_reg < fan_in)
                begin
                    p1_next = 1'b1;
                    j_next  = j_reg + CW'(1);
                end
                else if (!p1_reg && !p2_reg)
                begin
                    state_next = S_LEND;
                end
            end
            S_LEND:
            begin
                sat_next  = sat_reg || acc_sat;
                base_next = base_reg + WAW'((k_reg == 2'd0) ? MAX_INPUTS : MAX_WIDTH);
                i_next    = i_reg + CW'(1);
                if ((3'(k_reg) + 3'd1 == layers) && (i_reg == '0))
                begin
                    score_next = neuron_val;
                end
                state_next = S_LBIAS;
                if (32'(i_reg) + 1 == 32'(width_k))
                begin
                    i_next = '0;
                    if (3'(k_reg) + 3'd1 == layers)
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        k_next    = k_reg + 2'd1;
                        base_next = layer_base(k_reg + 2'd1);
                    end
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next       = 1'b1;
                    out_data_next.score  = score_reg;
                    out_data_next.status = sat_reg ? 2'(nms_pkg::ST_SAT) : status_reg;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            p1_reg        <= 1'b0;
            p2_reg        <= 1'b0;
            zv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            p1_reg        <= p1_next;
            p2_reg        <= p1_reg;
            zv_reg        <= zv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        prod_reg     <= signed'(weight_rdata) * signed'(src_data);
        zero_reg     <= zero_next;
        sat_reg      <= sat_next;
        score_reg    <= score_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign idle      = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
